>>> rtl/core/fcod_pkg.sv
// Shared types and constants of the fiducial code and orientation decoder.
// No dependencies; every other file of the block imports this package.
`default_nettype none

package fcod_pkg;

  // Fixed field widths of the channels
  localparam int SAMPLE_PORT_W  = 16;
  localparam int SAMPLE_W_DEF   = 16;
  localparam int STATUS_W       = 2;
  localparam int ORIENT_W       = 2;
  localparam int CODE_W         = 5;

  // Grid geometry
  localparam int GRID_CELLS     = 16;
  localparam int CELL_W         = 4;
  localparam int GATHER_BITS    = 7;
  localparam int CHECK_W        = 2;

  // Result status codes
  localparam logic [STATUS_W-1:0] STATUS_VALID     = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_NO_ORIENT = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_BAD_CHECK = 2'd2;

  // Cell picked for each gathered bit, per orientation; first entry is the MSB
  localparam logic [CELL_W-1:0] GATHER_TABLE [4][GATHER_BITS] = '{
    '{4'd9,  4'd5,  4'd14, 4'd10, 4'd6,  4'd15, 4'd11},
    '{4'd10, 4'd9,  4'd7,  4'd6,  4'd5,  4'd3,  4'd2},
    '{4'd6,  4'd10, 4'd1,  4'd5,  4'd9,  4'd0,  4'd4},
    '{4'd5,  4'd6,  4'd8,  4'd9,  4'd10, 4'd12, 4'd13}
  };

  // Commands from the controller to the datapath
  typedef struct packed {
    logic              wr;        // store the accepted beat
    logic [CELL_W-1:0] slot;      // grid cell the beat lands in
    logic              first;     // beat opens a grid: reload min and max
    logic              classify;  // threshold all cells into dark bits
    logic              decode;    // resolve orientation and code
  } fcod_cmd_t;

endpackage

`default_nettype wire

>>> rtl/core/fcod_in_if.sv
// Sample channel of the decoder: valid/ready handshake with one grid sample.
// Depends on fcod_pkg for the field widths.
`default_nettype none

interface fcod_in_if import fcod_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic [SAMPLE_PORT_W-1:0] sample;
  logic                     frame_start;

  modport source (output valid, output sample, output frame_start, input ready);
  modport sink   (input valid, input sample, input frame_start, output ready);
endinterface

`default_nettype wire

>>> rtl/core/fcod_out_if.sv
// Result channel of the decoder: valid/ready handshake with the decoded marker.
// Depends on fcod_pkg for the field widths.
`default_nettype none

interface fcod_out_if import fcod_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] status;
  logic [ORIENT_W-1:0] orientation;
  logic [CODE_W-1:0]   marker_code;

  modport source (output valid, output status, output orientation, output marker_code,
                  input ready);
  modport sink   (input valid, input status, input orientation, input marker_code,
                  output ready);
endinterface

`default_nettype wire

>>> rtl/core/fcod_ctrl.sv
// Controller of the decoder: cell counter, handshakes and decision sequencing.
// Depends on fcod_pkg; drives the command struct of fcod_datapath.
`default_nettype none

module fcod_ctrl
  import fcod_pkg::*;
(
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      in_valid_i,
  input  wire logic      frame_start_i,
  output logic           in_ready_o,
  input  wire logic      out_ready_i,
  output logic           out_valid_o,
  output fcod_cmd_t      cmd_o
);

  typedef enum logic [1:0] {
    ST_COLLECT,
    ST_CLASSIFY,
    ST_DECODE,
    ST_OFFER
  } state_e;

  localparam logic [CELL_W-1:0] LAST_CELL = CELL_W'(GRID_CELLS - 1);

  state_e            state_q, state_d;
  logic [CELL_W-1:0] count_q, count_d;
  logic              valid_q, valid_d;
  logic [CELL_W-1:0] slot;
  logic              accept;

  // Stall the grid-closing beat while an earlier decision is still in flight
  assign in_ready_o = !((count_q == LAST_CELL) && (state_q != ST_COLLECT));
  assign accept     = in_valid_i && in_ready_o;
  assign slot       = frame_start_i ? '0 : count_q;

  // Next state, counter and result valid
  always_comb begin
    state_d = state_q;
    count_d = count_q;
    valid_d = valid_q;
    if (accept) begin
      count_d = slot + CELL_W'(1);
    end
    case (state_q)
      ST_COLLECT: begin
        if (accept && (slot == LAST_CELL)) begin
          state_d = ST_CLASSIFY;
        end
      end
      ST_CLASSIFY: begin
        state_d = ST_DECODE;
      end
      ST_DECODE: begin
        state_d = ST_OFFER;
        valid_d = 1'b1;
      end
      ST_OFFER: begin
        if (out_ready_i) begin
          state_d = ST_COLLECT;
          valid_d = 1'b0;
        end
      end
      default: begin
        state_d = ST_COLLECT;
        valid_d = 1'b0;
      end
    endcase
  end

  // Hold state and registered outputs
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_COLLECT;
      count_q <= '0;
      valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      valid_q <= valid_d;
    end
  end

  assign out_valid_o = valid_q;

  // Commands to the datapath
  always_comb begin
    cmd_o.wr       = accept;
    cmd_o.slot     = slot;
    cmd_o.first    = (slot == '0);
    cmd_o.classify = (state_q == ST_CLASSIFY);
    cmd_o.decode   = (state_q == ST_DECODE);
  end

endmodule

`default_nettype wire

>>> rtl/core/fcod_datapath.sv
// Datapath of the decoder: sample registers, running extremes, threshold bits,
// orientation search, gather and checksum. Depends on fcod_pkg.
`default_nettype none

module fcod_datapath
  import fcod_pkg::*;
#(
  parameter int SAMPLE_WIDTH = SAMPLE_W_DEF
) (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire fcod_cmd_t                cmd_i,
  input  wire logic [SAMPLE_PORT_W-1:0] sample_i,
  output logic [STATUS_W-1:0]           status_o,
  output logic [ORIENT_W-1:0]           orientation_o,
  output logic [CODE_W-1:0]             marker_code_o
);

  // Only the low bits of the port carry the sample
  localparam int SW = (SAMPLE_WIDTH < SAMPLE_PORT_W) ? SAMPLE_WIDTH : SAMPLE_PORT_W;

  logic [SW-1:0]         store_q [GRID_CELLS];
  logic [SW-1:0]         min_q, max_q;
  logic [SW-1:0]         smp;
  logic [SW:0]           sum;
  logic [GRID_CELLS-1:0] dark_d, dark_q;
  logic [3:0]            side;
  logic                  found;
  logic [ORIENT_W-1:0]   rot;
  logic [GATHER_BITS-1:0] word;
  logic [CHECK_W-1:0]    ones;
  logic [STATUS_W-1:0]   status_q;
  logic [ORIENT_W-1:0]   orient_q;
  logic [CODE_W-1:0]     code_q;

  assign smp = sample_i[SW-1:0];

  // Store the beat in its cell
  always_ff @(posedge clk_i) begin
    if (cmd_i.wr) begin
      store_q[cmd_i.slot] <= smp;
    end
  end

  // Track the extremes of the grid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_q <= '0;
      max_q <= '0;
    end else if (cmd_i.wr) begin
      if (cmd_i.first) begin
        min_q <= smp;
        max_q <= smp;
      end else begin
        if (smp < min_q) min_q <= smp;
        if (smp > max_q) max_q <= smp;
      end
    end
  end

  // Mark a cell dark when twice its sample does not exceed min plus max
  assign sum = {1'b0, min_q} + {1'b0, max_q};
  always_comb begin
    for (int i = 0; i < GRID_CELLS; i++) begin
      dark_d[i] = ({store_q[i], 1'b0} <= sum);
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.classify) begin
      dark_q <= dark_d;
    end
  end

  // Border sides: top, right, bottom, left
  assign side[0] = &dark_q[3:0];
  assign side[1] = dark_q[3] & dark_q[7] & dark_q[11] & dark_q[15];
  assign side[2] = &dark_q[15:12];
  assign side[3] = dark_q[0] & dark_q[4] & dark_q[8] & dark_q[12];

  // Pick the rotation whose pair of adjacent sides is dark
  always_comb begin
    found = 1'b1;
    rot   = '0;
    case (side)
      4'b0011: rot = 2'd3;
      4'b0110: rot = 2'd2;
      4'b1100: rot = 2'd1;
      4'b1001: rot = 2'd0;
      default: found = 1'b0;
    endcase
  end

  // Gather the seven cells, first one into the MSB, and count the code ones
  always_comb begin
    for (int i = 0; i < GATHER_BITS; i++) begin
      word[GATHER_BITS-1-i] = dark_q[GATHER_TABLE[rot][i]];
    end
    ones = CHECK_W'($countones(word[CODE_W-1:0]));
  end

  // Load the result register
  always_ff @(posedge clk_i) begin
    if (cmd_i.decode) begin
      if (!found) begin
        status_q <= STATUS_NO_ORIENT;
        orient_q <= '0;
        code_q   <= '0;
      end else begin
        status_q <= (ones == word[GATHER_BITS-1 -: CHECK_W]) ? STATUS_VALID
                                                             : STATUS_BAD_CHECK;
        orient_q <= rot;
        code_q   <= word[CODE_W-1:0];
      end
    end
  end

  assign status_o      = status_q;
  assign orientation_o = orient_q;
  assign marker_code_o = code_q;

endmodule

`default_nettype wire

>>> rtl/core/fiducial_code_orientation_decoder.sv
// Channel   Dir  Beat
// in_i      in   sample[15:0], frame_start  (one grid sample, row-major)
// res_o     out  status[1:0], orientation[1:0], marker_code[4:0]
//
// One sample is taken per cycle while ready is high. The beat that closes a
// grid starts the decision (threshold, then orientation and gather); the
// result is then offered and held until taken.
// The closing beat of the next grid is stalled while a result is in flight.
// Reset clears the cell counter, extremes and result valid; samples are not cleared.
// Top level of the decoder; depends on fcod_pkg, fcod_in_if, fcod_out_if,
// fcod_ctrl and fcod_datapath.
`default_nettype none

module fiducial_code_orientation_decoder
  import fcod_pkg::*;
#(
  parameter int SAMPLE_WIDTH = SAMPLE_W_DEF
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  fcod_in_if.sink   in_i,
  fcod_out_if.source res_o
);

  fcod_cmd_t cmd;

  // Sequence the grid and the decision
  fcod_ctrl u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_i.valid),
    .frame_start_i (in_i.frame_start),
    .in_ready_o    (in_i.ready),
    .out_ready_i   (res_o.ready),
    .out_valid_o   (res_o.valid),
    .cmd_o         (cmd)
  );

  // Hold samples and compute the result
  fcod_datapath #(
    .SAMPLE_WIDTH (SAMPLE_WIDTH)
  ) u_datapath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .sample_i      (in_i.sample),
    .status_o      (res_o.status),
    .orientation_o (res_o.orientation),
    .marker_code_o (res_o.marker_code)
  );

endmodule

`default_nettype wire

>>> bench/fcod_marker_checker.sv
// Beat monitor and result predictor for the fiducial code and orientation decoder.
// Depends on fcod_pkg, fcod_in_if and fcod_out_if; instantiated by tb.
`default_nettype none

module fcod_marker_checker
  import fcod_pkg::*;
#(
  parameter int SAMPLE_WIDTH = SAMPLE_W_DEF
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  fcod_in_if        in_mon,
  fcod_out_if       res_mon,
  output int        mismatch_count_o,
  output int        pending_o
);

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [ORIENT_W-1:0] orientation;
    logic [CODE_W-1:0]   marker_code;
  } marker_t;

  // Bits of the sample port that the block actually uses
  localparam logic [SAMPLE_PORT_W-1:0] USED_BITS =
    SAMPLE_PORT_W'((64'd1 << SAMPLE_WIDTH) - 64'd1);

  marker_t                  expected_markers [$];
  logic [SAMPLE_PORT_W-1:0] grid_samples [GRID_CELLS];
  logic [CELL_W-1:0]        next_cell;
  logic [SAMPLE_PORT_W-1:0] lo_seen;
  logic [SAMPLE_PORT_W-1:0] hi_seen;
  logic [SAMPLE_PORT_W-1:0] cur_sample;
  marker_t                  got_marker;
  marker_t                  want_marker;
  int                       mismatches = 0;

  // Print one line per mismatch and count it
  task automatic report_mismatch(input string what, input logic [7:0] got,
                                 input logic [7:0] want);
    $display("[%0t] mismatch on %s: got %0h, expected %0h", $time, what, got, want);
    mismatches++;
  endtask

  // Threshold the buffered grid, find the rotation and gather the code
  function automatic marker_t decode_grid();
    logic [GRID_CELLS-1:0]    dark;
    logic [SAMPLE_PORT_W+1:0] level_sum;
    logic                     top_d, right_d, bottom_d, left_d;
    logic [ORIENT_W-1:0]      rot;
    logic                     found;
    logic [GATHER_BITS-1:0]   word;
    logic [CHECK_W-1:0]       ones;
    logic                     bit_v;
    marker_t                  m;
    level_sum = {2'b00, lo_seen} + {2'b00, hi_seen};
    for (int i = 0; i < GRID_CELLS; i++) begin
      dark[i] = ({1'b0, grid_samples[i], 1'b0} > level_sum) ? 1'b0 : 1'b1;
    end
    top_d    = &dark[3:0];
    bottom_d = &dark[15:12];
    right_d  = dark[3] & dark[7] & dark[11] & dark[15];
    left_d   = dark[0] & dark[4] & dark[8] & dark[12];
    found = 1'b1;
    rot   = '0;
    case ({top_d, right_d, bottom_d, left_d})
      4'b1100: rot = 2'd3;
      4'b0110: rot = 2'd2;
      4'b0011: rot = 2'd1;
      4'b1001: rot = 2'd0;
      default: found = 1'b0;
    endcase
    if (!found) begin
      m.status      = STATUS_NO_ORIENT;
      m.orientation = '0;
      m.marker_code = '0;
      return m;
    end
    word = '0;
    ones = '0;
    for (int i = 0; i < GATHER_BITS; i++) begin
      bit_v = dark[GATHER_TABLE[rot][i]];
      word  = {word[GATHER_BITS-2:0], bit_v};
      if (i >= CHECK_W && bit_v) ones = ones + 1'b1;
    end
    m.status      = (ones == word[GATHER_BITS-1 -: CHECK_W]) ? STATUS_VALID : STATUS_BAD_CHECK;
    m.orientation = rot;
    m.marker_code = word[CODE_W-1:0];
    return m;
  endfunction

  // Check result beats first, then take the sample beat of the same edge
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      next_cell = '0;
      lo_seen   = '0;
      hi_seen   = '0;
      expected_markers.delete();
      pending_o        = 0;
      mismatch_count_o = mismatches;
    end else begin
      if (res_mon.valid === 1'b1 && res_mon.ready === 1'b1) begin
        got_marker = '{res_mon.status, res_mon.orientation, res_mon.marker_code};
        if (expected_markers.size() == 0) begin
          report_mismatch("result beat with no grid pending", 8'(got_marker), 8'h0);
        end else begin
          want_marker = expected_markers.pop_front();
          if (got_marker.status !== want_marker.status)
            report_mismatch("status", 8'(got_marker.status), 8'(want_marker.status));
          if (got_marker.orientation !== want_marker.orientation)
            report_mismatch("orientation", 8'(got_marker.orientation),
                            8'(want_marker.orientation));
          if (got_marker.marker_code !== want_marker.marker_code)
            report_mismatch("marker_code", 8'(got_marker.marker_code),
                            8'(want_marker.marker_code));
        end
      end
      if (in_mon.valid === 1'b1 && in_mon.ready === 1'b1) begin
        cur_sample = in_mon.sample & USED_BITS;
        if (in_mon.frame_start) next_cell = '0;
        grid_samples[next_cell] = cur_sample;
        // First cell of a grid reloads both extremes
        if (next_cell == '0) begin
          lo_seen = cur_sample;
          hi_seen = cur_sample;
        end else begin
          if (cur_sample < lo_seen) lo_seen = cur_sample;
          if (cur_sample > hi_seen) hi_seen = cur_sample;
        end
        if (next_cell == CELL_W'(GRID_CELLS - 1)) expected_markers.push_back(decode_grid());
        next_cell = next_cell + 1'b1;
      end
      pending_o        = expected_markers.size();
      mismatch_count_o = mismatches;
    end
  end

endmodule

`default_nettype wire

>>> bench/tb.sv
// Top of the decoder bench: clock, reset, sample stimulus and result back-pressure.
// Depends on fcod_pkg, both channel interfaces, the decoder and fcod_marker_checker.
`default_nettype none

module tb;
  import fcod_pkg::*;

  localparam int CLK_HALF      = 6;
  localparam int RESET_CYCLES  = 10;
  localparam int TOTAL_BEATS   = 1150;
  localparam int QUIET_FROM    = 450;
  localparam int QUIET_TO      = 700;
  localparam int DRAIN_CYCLES  = 20;
  localparam int CYCLE_LIMIT   = 200000;
  localparam int IDLE_PERCENT  = 19;

  // Grid shapes; 0..3 are the marker rotations
  localparam int NO_MARKER     = 4;
  // Checksum handling of a generated marker
  localparam int CHECK_RANDOM  = 0;
  localparam int CHECK_GOOD    = 1;
  localparam int CHECK_BAD     = 2;

  // Border sides: top, right, bottom, left
  localparam logic [3:0][15:0] SIDE_CELLS = {16'h1111, 16'hF000, 16'h8888, 16'h000F};
  // Non-corner cells of each side
  localparam logic [3:0][1:0][3:0] SIDE_INNER =
    {{4'd8, 4'd4}, {4'd14, 4'd13}, {4'd11, 4'd7}, {4'd2, 4'd1}};

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;
  logic src_idle_en  = 1'b0;
  logic sink_idle_en = 1'b0;
  int   beats_sent   = 0;
  int   cycle_count  = 0;
  int   mismatch_count;
  int   pending_markers;

  fcod_in_if  in_ch ();
  fcod_out_if res_ch ();

  fiducial_code_orientation_decoder u_top (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_ch),
    .res_o  (res_ch)
  );

  fcod_marker_checker u_checker (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_mon           (in_ch),
    .res_mon          (res_ch),
    .mismatch_count_o (mismatch_count),
    .pending_o        (pending_markers)
  );

  always #CLK_HALF clk_i = ~clk_i;

  // Watchdog
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  // Result back-pressure
  always @(negedge clk_i) begin
    if (sink_idle_en) res_ch.ready <= ($urandom_range(0, 99) >= IDLE_PERCENT);
    else res_ch.ready <= 1'b1;
  end

  // Offer one sample beat and hold it until taken; returns on a falling edge
  task automatic send_sample(input logic [SAMPLE_PORT_W-1:0] value, input logic first);
    while (src_idle_en && $urandom_range(0, 99) < IDLE_PERCENT) begin
      in_ch.valid  <= 1'b0;
      in_ch.sample <= SAMPLE_PORT_W'($urandom);
      @(negedge clk_i);
    end
    in_ch.valid       <= 1'b1;
    in_ch.sample      <= value;
    in_ch.frame_start <= first;
    @(posedge clk_i);
    while (in_ch.ready !== 1'b1) @(posedge clk_i);
    @(negedge clk_i);
    beats_sent++;
  endtask

  // Dark-cell map of a grid: random cells, borders shaped for the rotation
  function automatic logic [GRID_CELLS-1:0] marker_pattern(input int rot, input int check_mode);
    logic [GRID_CELLS-1:0] d;
    logic [1:0]            ones;
    d = GRID_CELLS'($urandom);
    if (rot == NO_MARKER) return d;
    for (int s = 0; s < 4; s++) begin
      if (s == 3 - rot || s == (4 - rot) % 4) d = d | SIDE_CELLS[s];
    end
    // Break any other side that came out all dark
    for (int s = 0; s < 4; s++) begin
      if (!(s == 3 - rot || s == (4 - rot) % 4) && (d & SIDE_CELLS[s]) == SIDE_CELLS[s])
        d[SIDE_INNER[s][$urandom_range(0, 1)]] = 1'b0;
    end
    if (check_mode != CHECK_RANDOM) begin
      ones = '0;
      for (int i = CHECK_W; i < GATHER_BITS; i++) ones = ones + d[GATHER_TABLE[rot][i]];
      if (check_mode == CHECK_BAD) ones = ones + 1'b1;
      d[GATHER_TABLE[rot][0]] = ones[1];
      d[GATHER_TABLE[rot][1]] = ones[0];
    end
    return d;
  endfunction

  // Send a full grid: dark cells near lo, light cells near hi
  task automatic send_grid(input int rot, input int check_mode,
                           input logic [SAMPLE_PORT_W-1:0] lo,
                           input logic [SAMPLE_PORT_W-1:0] hi, input logic first);
    logic [GRID_CELLS-1:0] dark;
    int                    span;
    int                    jit;
    dark = marker_pattern(rot, check_mode);
    span = (int'(hi) - int'(lo)) / 8;
    for (int i = 0; i < GRID_CELLS; i++) begin
      jit = $urandom_range(0, span);
      send_sample(dark[i] ? lo + SAMPLE_PORT_W'(jit) : hi - SAMPLE_PORT_W'(jit),
                  (i == 0) ? first : 1'b0);
    end
  endtask

  // Open a grid and drop it part way
  task automatic send_fragment(input int count);
    for (int i = 0; i < count; i++) send_sample(SAMPLE_PORT_W'($urandom), i == 0);
  endtask

  initial begin
    int                       pick;
    int                       noise_len;
    logic [SAMPLE_PORT_W-1:0] a;
    logic [SAMPLE_PORT_W-1:0] b;
    logic                     aligned;
    logic                     drained;
    in_ch.valid       = 1'b0;
    in_ch.sample      = '0;
    in_ch.frame_start = 1'b0;
    res_ch.ready      = 1'b0;
    aligned = 1'b1;
    drained = 1'b0;

    repeat (RESET_CYCLES) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // Directed: flat grids, each rotation, checksum failure, restart and wrap
    send_grid(NO_MARKER, CHECK_RANDOM, 16'h0000, 16'h0000, 1'b1);
    send_grid(NO_MARKER, CHECK_RANDOM, 16'hFFFF, 16'hFFFF, 1'b0);
    for (int r = 0; r < 4; r++) send_grid(r, CHECK_GOOD, 16'h0000, 16'hFFFF, r == 0);
    send_grid(1, CHECK_BAD, 16'h0100, 16'hFF00, 1'b0);
    send_fragment(5);
    send_grid(2, CHECK_BAD, 16'h0000, 16'hFFFF, 1'b1);
    send_grid(NO_MARKER, CHECK_RANDOM, 16'h0000, 16'hFFFF, 1'b0);

    // Random: mostly whole grids, some noise and dropped grids
    while (beats_sent < TOTAL_BEATS) begin
      src_idle_en  = !(beats_sent >= QUIET_FROM && beats_sent < QUIET_TO);
      sink_idle_en = src_idle_en;
      // Hold off once until every pending result is out
      if (!drained && beats_sent >= QUIET_TO) begin
        drained = 1'b1;
        if (pending_markers != 0) begin
          in_ch.valid <= 1'b0;
          while (pending_markers != 0) @(negedge clk_i);
        end
      end
      a = SAMPLE_PORT_W'($urandom);
      b = SAMPLE_PORT_W'($urandom);
      if ($urandom_range(0, 9) == 0) begin
        a = '0;
        b = '1;
      end
      pick = $urandom_range(0, 99);
      if (pick < 8) begin
        noise_len = $urandom_range(1, 6);
        for (int i = 0; i < noise_len; i++)
          send_sample(SAMPLE_PORT_W'($urandom), $urandom_range(0, 99) < 30);
        aligned = 1'b0;
      end else if (pick < 16) begin
        send_fragment($urandom_range(1, GRID_CELLS - 1));
        aligned = 1'b0;
      end else begin
        send_grid((pick < 28) ? NO_MARKER : $urandom_range(0, 3),
                  ($urandom_range(0, 9) < 6) ? CHECK_GOOD : CHECK_RANDOM,
                  (a < b) ? a : b, (a < b) ? b : a,
                  !aligned || $urandom_range(0, 3) == 0);
        aligned = 1'b1;
      end
    end

    // Drain and give the verdict
    in_ch.valid <= 1'b0;
    while (pending_markers != 0) @(negedge clk_i);
    repeat (DRAIN_CYCLES) @(negedge clk_i);
    if (mismatch_count == 0 && pending_markers == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

`default_nettype wire

>>> sim.f
rtl/core/fcod_pkg.sv
rtl/core/fcod_in_if.sv
rtl/core/fcod_out_if.sv
rtl/core/fcod_ctrl.sv
rtl/core/fcod_datapath.sv
rtl/core/fiducial_code_orientation_decoder.sv
bench/fcod_marker_checker.sv
bench/tb.sv
